// ===== rtl/dest_list_frame_classifier_core_macros.svh =====
// ---------------------------------------------------------------------------
// dest_list_frame_classifier_core assertion macros
// Shared concurrent assertion shorthands for the classifier checker.
// ---------------------------------------------------------------------------
`ifndef DEST_LIST_FRAME_CLASSIFIER_CORE_MACROS_SVH
`define DEST_LIST_FRAME_CLASSIFIER_CORE_MACROS_SVH

// same-cycle implication, masked while reset is asserted
`define DLFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dlfc assertion failed");

// next-cycle implication, masked while reset is asserted
`define DLFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dlfc assertion failed");

// next-cycle implication that is also checked across reset
`define DLFC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dlfc assertion failed");

`endif

// ===== rtl/dlfc_pkg.sv =====
// ---------------------------------------------------------------------------
// dlfc_pkg
// Shared types and constants of the destination-list frame classifier.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dlfc_pkg;

  // longest frame, in bytes, that is still classified normally
  localparam int MAX_FRAME_BYTES = 65535;

  // frame classes as reported on the result channel
  typedef enum logic [2:0] {
    CLS_SELF      = 3'd0,
    CLS_INCOMING  = 3'd1,
    CLS_GARBAGE   = 3'd2,
    CLS_NOT_MINE  = 3'd3,
    CLS_UNKNOWN   = 3'd4,
    CLS_MALFORMED = 3'd5,
    CLS_SIM_END   = 3'd6
  } cls_t;

  // one classification result
  typedef struct packed {
    cls_t        frame_class;
    logic [15:0] payload_offset;
    logic [15:0] payload_size;
  } result_t;

endpackage

// ===== rtl/dlfc_parser.sv =====
// ---------------------------------------------------------------------------
// dlfc_parser
// Byte-wide header parser: tracks the header phase, matches ids against
// the node id and forms the class of a frame on its last byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlfc_parser
  import dlfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        beat_take,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [15:0] node_id,
  output logic        res_valid,
  output result_t     res
);

  typedef enum logic [3:0] {
    PH_TYPE    = 4'd0,
    PH_SND_HI  = 4'd1,
    PH_SND_LO  = 4'd2,
    PH_NG_HI   = 4'd3,
    PH_NG_LO   = 4'd4,
    PH_GID_HI  = 4'd5,
    PH_GID_LO  = 4'd6,
    PH_NB_HI   = 4'd7,
    PH_NB_LO   = 4'd8,
    PH_BID_HI  = 4'd9,
    PH_BID_LO  = 4'd10,
    PH_PAYLOAD = 4'd11,
    PH_IGNORE  = 4'd12
  } phase_t;

  localparam logic [7:0]  TYPE_LISTED  = 8'd2;
  localparam logic [7:0]  TYPE_SIM_END = 8'd3;
  localparam logic [15:0] MAX_POS      = 16'(MAX_FRAME_BYTES);
  localparam logic [15:0] POS_SAT      = 16'hFFFF;

  phase_t      phase_r, phase_nxt, phase_upd;
  logic [15:0] pos_r, pos_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [15:0] left_r, left_nxt;
  logic        self_r, self_nxt;
  logic        good_r, good_nxt;
  logic        bad_r, bad_nxt;
  logic [15:0] hend_r, hend_nxt;
  cls_t        early_r, early_nxt;

  logic [15:0] word;
  logic        id_hit;
  logic [15:0] left_dec;
  logic [15:0] pos_inc;
  cls_t        cls;
  logic        has_payload;

  assign word     = {hold_r, data_byte};
  assign id_hit   = (word == node_id);
  assign left_dec = left_r - 16'd1;
  assign pos_inc  = pos_r + 16'd1;

  // header walk for one accepted beat
  always_comb begin
    phase_upd = phase_r;
    hold_nxt  = hold_r;
    left_nxt  = left_r;
    self_nxt  = self_r;
    good_nxt  = good_r;
    bad_nxt   = bad_r;
    hend_nxt  = hend_r;
    early_nxt = early_r;
    if (beat_take) begin
      case (phase_r)
        PH_TYPE: begin
          if (data_byte == TYPE_LISTED) begin
            phase_upd = PH_SND_HI;
          end else begin
            early_nxt = (data_byte == TYPE_SIM_END) ? CLS_SIM_END : CLS_UNKNOWN;
            phase_upd = PH_IGNORE;
          end
        end
        PH_SND_HI: begin
          hold_nxt  = data_byte;
          phase_upd = PH_SND_LO;
        end
        PH_SND_LO: begin
          self_nxt  = id_hit;
          phase_upd = PH_NG_HI;
        end
        PH_NG_HI: begin
          hold_nxt  = data_byte;
          phase_upd = PH_NG_LO;
        end
        PH_NG_LO: begin
          left_nxt  = word;
          phase_upd = (word == 16'd0) ? PH_NB_HI : PH_GID_HI;
        end
        PH_GID_HI: begin
          hold_nxt  = data_byte;
          phase_upd = PH_GID_LO;
        end
        PH_GID_LO: begin
          good_nxt  = good_r | id_hit;
          left_nxt  = left_dec;
          phase_upd = (left_dec == 16'd0) ? PH_NB_HI : PH_GID_HI;
        end
        PH_NB_HI: begin
          hold_nxt  = data_byte;
          phase_upd = PH_NB_LO;
        end
        PH_NB_LO: begin
          left_nxt = word;
          if (word == 16'd0) begin
            phase_upd = PH_PAYLOAD;
            hend_nxt  = pos_inc;
          end else begin
            phase_upd = PH_BID_HI;
          end
        end
        PH_BID_HI: begin
          hold_nxt  = data_byte;
          phase_upd = PH_BID_LO;
        end
        PH_BID_LO: begin
          bad_nxt  = bad_r | id_hit;
          left_nxt = left_dec;
          if (left_dec == 16'd0) begin
            phase_upd = PH_PAYLOAD;
            hend_nxt  = pos_inc;
          end else begin
            phase_upd = PH_BID_HI;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // frame class from the state after this beat
  always_comb begin
    has_payload = 1'b0;
    if (pos_r >= MAX_POS) begin
      cls = CLS_MALFORMED;
    end else if (phase_upd == PH_IGNORE) begin
      cls = early_nxt;
    end else if (phase_upd != PH_PAYLOAD) begin
      cls = CLS_MALFORMED;
    end else if (self_nxt) begin
      cls         = CLS_SELF;
      has_payload = 1'b1;
    end else if (good_nxt && bad_nxt) begin
      cls = CLS_MALFORMED;
    end else if (good_nxt) begin
      cls         = CLS_INCOMING;
      has_payload = 1'b1;
    end else if (bad_nxt) begin
      cls         = CLS_GARBAGE;
      has_payload = 1'b1;
    end else begin
      cls         = CLS_NOT_MINE;
      has_payload = 1'b1;
    end
  end

  assign res_valid          = beat_take & last_byte;
  assign res.frame_class    = cls;
  assign res.payload_offset = has_payload ? hend_nxt : 16'd0;
  assign res.payload_size   = has_payload ? (pos_inc - hend_nxt) : 16'd0;

  // byte count, saturating; the whole frame state restarts after a last beat
  always_comb begin
    phase_nxt = phase_upd;
    pos_nxt   = pos_r;
    if (beat_take) begin
      if (last_byte) begin
        phase_nxt = PH_TYPE;
        pos_nxt   = 16'd0;
      end else if (pos_r != POS_SAT) begin
        pos_nxt = pos_inc;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n || res_valid) begin
      phase_r <= PH_TYPE;
      pos_r   <= 16'd0;
      hold_r  <= 8'd0;
      left_r  <= 16'd0;
      self_r  <= 1'b0;
      good_r  <= 1'b0;
      bad_r   <= 1'b0;
      hend_r  <= 16'd0;
      early_r <= CLS_SELF;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      hold_r  <= hold_nxt;
      left_r  <= left_nxt;
      self_r  <= self_nxt;
      good_r  <= good_nxt;
      bad_r   <= bad_nxt;
      hend_r  <= hend_nxt;
      early_r <= early_nxt;
    end
  end

endmodule

// ===== rtl/dlfc_out_buf.sv =====
// ---------------------------------------------------------------------------
// dlfc_out_buf
// Two-entry result buffer: output register plus skid register, so the
// parser keeps taking beats while a result waits on the receiver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlfc_out_buf
  import dlfc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  input  result_t push_res,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  logic    main_valid_r, main_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop = main_valid_r & ~out_stall;

  // drain into output register first, overflow into skid
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = 1'b0;
      end
    end
    if (push_valid) begin
      if (!main_valid_nxt) begin
        main_nxt       = push_res;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_res;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_res   = main_r;

endmodule

// ===== rtl/dest_list_frame_classifier_core.sv =====
// ---------------------------------------------------------------------------
// dest_list_frame_classifier_core
// Classifies listed frames by sender and destination lists, one byte a beat.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one frame byte per beat, in_last_byte on the final byte.
//   out_* : one result beat per frame (class, payload offset and size).
//   cfg_* : node id write, applied on the edge where cfg_wr_en is high;
//           change it only while no frame is in progress.
// Throughput: one byte per cycle while in_stall is low; the header parser
//   updates its phase register and compare flags once per byte.
// Result: a finished result is registered into the output or skid register.
// Stall: a result waiting on out_stall does not block input; a second
//   finished result lands in a skid register, and only while that one is
//   occupied is in_stall raised.
// Reset: rst_n low clears the node id to 0, the parser to the start of a
//   frame and both result slots to empty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dest_list_frame_classifier_core
  import dlfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_frame_class,
  output logic [15:0] out_payload_offset,
  output logic [15:0] out_payload_size,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_node_identifier
);

  logic [15:0] node_id_r;
  logic        beat_take;
  logic        res_valid;
  result_t     res;
  result_t     out_res;
  logic        buf_full;

  // node id register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r <= 16'd0;
    end else if (cfg_wr_en) begin
      node_id_r <= cfg_node_identifier;
    end
  end

  assign in_stall  = buf_full;
  assign beat_take = in_valid & ~buf_full;

  dlfc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_take (beat_take),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .node_id   (node_id_r),
    .res_valid (res_valid),
    .res       (res)
  );

  dlfc_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_valid),
    .push_res   (res),
    .full       (buf_full),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign out_frame_class    = out_res.frame_class;
  assign out_payload_offset = out_res.payload_offset;
  assign out_payload_size   = out_res.payload_size;

endmodule

// ===== rtl/dlfc_checker.sv =====
// ---------------------------------------------------------------------------
// dlfc_checker
// Port-level checks of the classifier, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dest_list_frame_classifier_core_macros.svh"

module dlfc_checker
  import dlfc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_frame_class,
  input logic [15:0] out_payload_offset,
  input logic [15:0] out_payload_size
);

  logic        no_payload_cls;
  logic        payload_cls;
  logic [16:0] frame_len;

  assign no_payload_cls = (out_frame_class == CLS_UNKNOWN) ||
                          (out_frame_class == CLS_MALFORMED) ||
                          (out_frame_class == CLS_SIM_END);
  assign payload_cls    = (out_frame_class == CLS_SELF) ||
                          (out_frame_class == CLS_INCOMING) ||
                          (out_frame_class == CLS_GARBAGE) ||
                          (out_frame_class == CLS_NOT_MINE);
  assign frame_len      = {1'b0, out_payload_offset} + {1'b0, out_payload_size};

  // a held result beat stays up
  `DLFC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // nothing comes out right after reset
  `DLFC_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

  // classes without payload report zero offset and size
  `DLFC_ASSERT_NOW(a_no_payload, clk, rst_n, out_valid && no_payload_cls,
                   out_payload_offset == 16'd0 && out_payload_size == 16'd0)

  // a complete header is at least seven bytes and the frame fits the bound
  `DLFC_ASSERT_NOW(a_payload_span, clk, rst_n, out_valid && payload_cls,
                   out_payload_offset >= 16'd7 && frame_len <= 17'(MAX_FRAME_BYTES))

  // classes above simulation end never appear
  `DLFC_ASSERT_NOW(a_class_range, clk, rst_n, out_valid, no_payload_cls || payload_cls)

endmodule

bind dest_list_frame_classifier_core dlfc_checker u_dlfc_checker (.*);
